// ===== hdl/xttw_pkg.sv =====
// Shared types and constants for the XOR threshold trie window block.
// Depends on nothing; xttw_walk, the top level and the testbench import it.
package xttw_pkg;

    localparam int KEY_W         = 32;    // width of the key and threshold fields
    localparam int OUT_POS_W     = 13;    // width of the position fields in a result
    localparam int MAX_ITEMS_DEF = 4096;
    localparam int KEY_BITS_DEF  = 32;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             start_sequence;
    } t_in_item;

    typedef struct packed {
        logic                 match_found;
        logic [OUT_POS_W-1:0] match_position;
        logic [OUT_POS_W-1:0] best_length;
        logic                 overflow;
    } t_out_item;

    // walker command, valid for the cycle the request is taken
    typedef struct packed {
        logic start;
        logic clear;
    } t_walk_ctl;

endpackage

// ===== hdl/xttw_node_ram.sv =====
// Trie node store: one write port, two read ports, registered read data.
// Depends on nothing.
module xttw_node_ram #(
    parameter int DEPTH  = 2,
    parameter int ADDR_W = 1,
    parameter int DATA_W = 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_ra_addr,
    output logic [DATA_W-1:0] o_ra_data,
    input  logic [ADDR_W-1:0] i_rb_addr,
    output logic [DATA_W-1:0] o_rb_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_ra_data;
    logic [DATA_W-1:0] r_rb_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_ra_data <= r_mem[i_ra_addr];
        r_rb_data <= r_mem[i_rb_addr];
    end

    assign o_ra_data = r_ra_data;
    assign o_rb_data = r_rb_data;

endmodule

// ===== hdl/xttw_walk.sv =====
// Trie walker: bit-serial insert walk then query walk, one trie level per cycle.
// Depends on xttw_pkg and xttw_node_ram.
module xttw_walk #(
    parameter int MAX_ITEMS = xttw_pkg::MAX_ITEMS_DEF,
    parameter int KEY_BITS  = xttw_pkg::KEY_BITS_DEF,
    localparam int POS_W    = $clog2(MAX_ITEMS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  xttw_pkg::t_walk_ctl         i_ctl,
    input  logic [xttw_pkg::KEY_W-1:0]  i_key,
    input  logic [xttw_pkg::KEY_W-1:0]  i_thr,
    input  logic [POS_W-1:0]            i_pos,
    output logic                        o_done,
    output logic [POS_W-1:0]            o_match
);
    import xttw_pkg::*;

    localparam int NODE_CAP = 1 + MAX_ITEMS * KEY_BITS;
    localparam int NODE_W   = $clog2(NODE_CAP);
    localparam int CNT_W    = $clog2(NODE_CAP + 1);
    localparam int ENT_W    = 2 * NODE_W + POS_W;
    localparam int LVL_W    = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(KEY_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_LEAF,
        S_QRY,
        S_LAST,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] r_thr;
    logic                r_thr_hi;
    logic [POS_W-1:0]    r_pos;
    logic [LVL_W-1:0]    r_lvl;
    logic [NODE_W-1:0]   r_cur;
    logic                r_cur_root;
    logic                r_fresh;
    logic [CNT_W-1:0]    r_used;
    logic [NODE_W-1:0]   r_root0;
    logic [NODE_W-1:0]   r_root1;
    logic [POS_W-1:0]    r_best;
    logic                r_pend;
    logic                r_dead;

    logic [ENT_W-1:0]    w_rd_a;
    logic [ENT_W-1:0]    w_rd_b;
    logic                w_we;
    logic [ENT_W-1:0]    w_wdata;
    logic [NODE_W-1:0]   w_ra_addr;

    logic                bit_k;
    logic                bit_t;
    logic [NODE_W-1:0]   l0;
    logic [NODE_W-1:0]   l1;
    logic [NODE_W-1:0]   wl0;
    logic [NODE_W-1:0]   wl1;
    logic [NODE_W-1:0]   lnk;
    logic                newn;
    logic [NODE_W-1:0]   nxt_ins;
    logic [NODE_W-1:0]   opp;
    logic [NODE_W-1:0]   same;
    logic [NODE_W-1:0]   q_nxt;
    logic [POS_W-1:0]    lat_a;
    logic [POS_W-1:0]    lat_b;
    logic [POS_W-1:0]    m1;
    logic [POS_W-1:0]    m2;
    logic                thr_hi;
    logic [KEY_BITS-1:0] key_rot;

    always_comb begin
        bit_k = r_key[KEY_BITS-1];
        bit_t = r_thr[KEY_BITS-1];
        if (r_cur_root) begin
            l0 = r_root0;
            l1 = r_root1;
        end else if (r_fresh) begin
            l0 = '0;
            l1 = '0;
        end else begin
            l0 = w_rd_a[POS_W +: NODE_W];
            l1 = w_rd_a[POS_W + NODE_W +: NODE_W];
        end
        lnk     = bit_k ? l1 : l0;
        newn    = (lnk == '0);
        nxt_ins = newn ? r_used[NODE_W-1:0] : lnk;
        opp     = bit_k ? l0 : l1;
        same    = bit_k ? l1 : l0;
        q_nxt   = bit_t ? opp : same;

        // candidate from the opposite child arrives on port B in the following cycle
        lat_a = w_rd_a[POS_W-1:0];
        lat_b = w_rd_b[POS_W-1:0];
        m1    = (r_pend && lat_b > r_best) ? lat_b : r_best;
        m2    = (!r_dead && lat_a > m1) ? lat_a : m1;

        wl0 = l0;
        wl1 = l1;
        if (r_state == S_INS && newn) begin
            if (bit_k) begin
                wl1 = nxt_ins;
            end else begin
                wl0 = nxt_ins;
            end
        end
        w_we      = (r_state == S_INS && !r_cur_root) || r_state == S_LEAF;
        w_wdata   = {wl1, wl0, r_pos};
        w_ra_addr = (r_state == S_QRY) ? q_nxt : nxt_ins;

        thr_hi  = ((i_thr >> KEY_BITS) != '0);
        key_rot = (r_key << 1) | (r_key >> (KEY_BITS - 1));
    end

    xttw_node_ram #(
        .DEPTH  (NODE_CAP),
        .ADDR_W (NODE_W),
        .DATA_W (ENT_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (r_cur),
        .i_wdata   (w_wdata),
        .i_ra_addr (w_ra_addr),
        .o_ra_data (w_rd_a),
        .i_rb_addr (opp),
        .o_rb_data (w_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= CNT_W'(1);
            r_root0    <= '0;
            r_root1    <= '0;
            r_cur_root <= 1'b1;
            r_fresh    <= 1'b0;
            r_pend     <= 1'b0;
            r_dead     <= 1'b0;
            r_best     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        if (i_ctl.clear) begin
                            r_used  <= CNT_W'(1);
                            r_root0 <= '0;
                            r_root1 <= '0;
                        end
                        r_key      <= i_key[KEY_BITS-1:0];
                        r_thr      <= i_thr[KEY_BITS-1:0];
                        r_thr_hi   <= thr_hi;
                        r_pos      <= i_pos;
                        r_lvl      <= LVL_MAX;
                        r_cur_root <= 1'b1;
                        r_fresh    <= 1'b0;
                        r_state    <= S_INS;
                    end
                end
                S_INS: begin
                    if (r_cur_root && newn) begin
                        if (bit_k) begin
                            r_root1 <= nxt_ins;
                        end else begin
                            r_root0 <= nxt_ins;
                        end
                    end
                    if (newn) begin
                        r_used <= r_used + CNT_W'(1);
                    end
                    r_cur      <= nxt_ins;
                    r_cur_root <= 1'b0;
                    r_fresh    <= newn;
                    r_key      <= key_rot;
                    if (r_lvl == '0) begin
                        r_state <= S_LEAF;
                    end else begin
                        r_lvl <= r_lvl - LVL_W'(1);
                    end
                end
                S_LEAF: begin
                    // key register has rotated back to its original order
                    r_cur_root <= 1'b1;
                    r_fresh    <= 1'b0;
                    r_lvl      <= LVL_MAX;
                    r_best     <= '0;
                    r_dead     <= r_thr_hi;
                    r_pend     <= 1'b0;
                    r_state    <= S_QRY;
                end
                S_QRY: begin
                    r_best <= m1;
                    r_pend <= !r_dead && !bit_t && (opp != '0);
                    if (!r_dead) begin
                        r_dead <= bit_t ? (opp == '0) : (same == '0);
                        r_cur  <= q_nxt;
                    end
                    r_cur_root <= 1'b0;
                    r_key      <= key_rot;
                    r_thr      <= r_thr << 1;
                    if (r_lvl == '0) begin
                        r_state <= S_LAST;
                    end else begin
                        r_lvl <= r_lvl - LVL_W'(1);
                    end
                end
                S_LAST: begin
                    r_best  <= m2;
                    r_pend  <= 1'b0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done  = (r_state == S_DONE);
    assign o_match = r_best;

endmodule

// ===== hdl/xor_threshold_trie_window.sv =====
// Top level of the XOR threshold trie window block: request handshakes,
// sequence counters, shortest window and the result register.
// Depends on xttw_pkg, xttw_walk and xttw_node_ram.
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data): one key per request;
//   start_sequence empties the trie and restarts positions before the key.
//   Output channel (o_out_valid / i_out_stall / o_out_data): one result per
//   request, in order. Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data)
//   writes the XOR threshold; write it only while the block is idle.
// Flow:
//   A key walks the trie bit-serially, one trie level at a time: first the insert
//   walk, then the query walk, both through the single node memory. A new request
//   is taken only once the previous result has moved into the output register. A
//   dropped key (capacity reached) skips both walks and goes straight to the
//   output register.
// Reset (synchronous, active low) empties the trie, clears positions, the
//   shortest window and the threshold. No memory clearing pass is needed:
//   nodes are fully written when allocated.
// Stall: the result register holds while i_out_stall is high; the next key is
//   still taken and walked, then waits for the register to drain.
module xor_threshold_trie_window #(
    parameter int MAX_ITEMS = xttw_pkg::MAX_ITEMS_DEF,
    parameter int KEY_BITS  = xttw_pkg::KEY_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  xttw_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output xttw_pkg::t_out_item         o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [xttw_pkg::KEY_W-1:0]  i_cfg_data
);
    import xttw_pkg::*;

    localparam int POS_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        T_IDLE,
        T_WALK,
        T_UPD,
        T_OUT
    } t_state;

    t_state           r_state;
    logic [POS_W-1:0] r_count;     // positions used in this sequence
    logic [POS_W-1:0] r_shortest;  // 0 means no window yet
    logic [POS_W-1:0] r_match;
    logic [KEY_W-1:0] r_thr;
    t_out_item        r_res;       // finished result waiting for the output register
    t_out_item        r_out;
    logic             r_out_valid;

    logic             accept;
    logic [POS_W-1:0] eff_count;
    logic [POS_W-1:0] eff_short;
    logic             is_ovf;
    logic [POS_W-1:0] w_pos;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] n_short;
    logic             out_free;
    t_walk_ctl        w_ctl;
    logic             w_done;
    logic [POS_W-1:0] w_match;

    always_comb begin
        accept    = i_in_valid && (r_state == T_IDLE);
        eff_count = i_in_data.start_sequence ? '0 : r_count;
        eff_short = i_in_data.start_sequence ? '0 : r_shortest;
        is_ovf    = (eff_count >= POS_W'(MAX_ITEMS));
        w_pos     = eff_count + POS_W'(1);

        w_ctl.start = accept && !is_ovf;
        w_ctl.clear = i_in_data.start_sequence;

        // window from the match to the current position, both ends included
        len = r_count - r_match + POS_W'(1);
        if (r_match != '0 && (r_shortest == '0 || len < r_shortest)) begin
            n_short = len;
        end else begin
            n_short = r_shortest;
        end

        out_free = !r_out_valid || !i_out_stall;
    end

    xttw_walk #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_BITS  (KEY_BITS)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_key   (i_in_data.key),
        .i_thr   (r_thr),
        .i_pos   (w_pos),
        .o_done  (w_done),
        .o_match (w_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_count     <= '0;
            r_shortest  <= '0;
            r_match     <= '0;
            r_thr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        r_shortest <= eff_short;
                        if (is_ovf) begin
                            // dropped key: state stays as it is
                            r_count              <= eff_count;
                            r_res.match_found    <= 1'b0;
                            r_res.match_position <= '0;
                            r_res.best_length    <= OUT_POS_W'(eff_short);
                            r_res.overflow       <= 1'b1;
                            r_state              <= T_OUT;
                        end else begin
                            r_count <= w_pos;
                            r_state <= T_WALK;
                        end
                    end
                end
                T_WALK: begin
                    if (w_done) begin
                        r_match <= w_match;
                        r_state <= T_UPD;
                    end
                end
                T_UPD: begin
                    r_shortest           <= n_short;
                    r_res.match_found    <= (r_match != '0);
                    r_res.match_position <= OUT_POS_W'(r_match);
                    r_res.best_length    <= OUT_POS_W'(n_short);
                    r_res.overflow       <= 1'b0;
                    r_state              <= T_OUT;
                end
                T_OUT: begin
                    if (out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != T_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for xor_threshold_trie_window: a bit-serial trie predictor,
// random key streams and random idling on both channels.
// Depends on xttw_pkg and the xor_threshold_trie_window RTL.
module tb;
    import xttw_pkg::*;

    localparam int          TRIE_KEY_BITS = KEY_BITS_DEF;
    localparam int          SEQ_CAPACITY  = MAX_ITEMS_DEF;
    localparam int unsigned NODE_CAP      = 1 + SEQ_CAPACITY * TRIE_KEY_BITS;
    // Sized for an insert walk plus a query walk, with margin.
    localparam int          SETTLE_CYCLES = 2 * TRIE_KEY_BITS + 8;
    localparam int          PHASE_COUNT   = 12;
    localparam int          PHASE_KEYS    = 140;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          STEADY_KEYS   = 40;
    // Watchdog limit in time units; the clock period is 10 units.
    localparam longint      RUN_LIMIT     = 8_000_000;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    t_in_item       in_data   = '0;
    logic           out_stall = 1'b0;
    logic           cfg_valid = 1'b0;
    logic [KEY_W-1:0] cfg_data = '0;
    logic           in_stall;
    logic           out_valid;
    t_out_item      out_data;
    logic           cfg_ready;

    // Predictor state: trie, sequence counters and the threshold register.
    int unsigned      trie_next   [NODE_CAP][2];
    int unsigned      trie_latest [NODE_CAP];
    int unsigned      trie_nodes   = 1;
    int unsigned      seq_pos      = 0;
    int unsigned      seq_shortest = 0;
    logic [KEY_W-1:0] thr_model    = '0;

    t_out_item        window_reports_due[$];
    logic [KEY_W-1:0] recent_keys[$];
    logic [KEY_W-1:0] key_base = '0;

    // Pacing: steady stretches flip on and off at random unless pinned.
    bit          pace_random  = 1'b1;
    bit          tx_steady    = 1'b0;
    bit          rx_steady    = 1'b0;
    int unsigned hold_request = 0;

    int unsigned keys_sent        = 0;
    int unsigned reports_checked  = 0;
    int unsigned match_reports    = 0;
    int unsigned overflow_reports = 0;
    int unsigned settings_used    = 0;
    int unsigned mismatches       = 0;

    always #5 clk = ~clk;

    xor_threshold_trie_window dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // Expected result for one accepted request. The key is inserted first, so
    // a zero threshold always finds the key's own position.
    function automatic t_out_item window_predict(input t_in_item req);
        t_out_item        res;
        logic [KEY_W-1:0] key;
        int unsigned      cur, nxt, opp, same, best, len;
        int               b;
        logic             kb;
        bit               walking;
        res = '0;
        key = req.key;
        if (req.start_sequence) begin
            trie_next[0][0] = 0;
            trie_next[0][1] = 0;
            trie_latest[0]  = 0;
            trie_nodes      = 1;
            seq_pos         = 0;
            seq_shortest    = 0;
        end
        // Sequence full: key dropped, state untouched.
        if (seq_pos >= SEQ_CAPACITY) begin
            res.best_length = OUT_POS_W'(seq_shortest);
            res.overflow    = 1'b1;
            return res;
        end
        seq_pos++;

        // Insert from the top bit down, tagging every node on the path.
        cur = 0;
        for (b = TRIE_KEY_BITS - 1; b >= 0; b--) begin
            kb  = key[b];
            nxt = trie_next[cur][kb];
            if (nxt == 0) begin
                if (trie_nodes >= NODE_CAP)
                    break;
                nxt = trie_nodes;
                trie_nodes++;
                trie_next[nxt][0] = 0;
                trie_next[nxt][1] = 0;
                trie_next[cur][kb] = nxt;
            end
            cur = nxt;
            trie_latest[cur] = seq_pos;
        end

        // Query: set threshold bit must flip; clear bit lets the flipped subtree
        // qualify outright and keeps following the same bit.
        best    = 0;
        cur     = 0;
        walking = ((64'(thr_model) >> TRIE_KEY_BITS) == 0);
        for (b = TRIE_KEY_BITS - 1; b >= 0 && walking; b--) begin
            kb   = key[b];
            opp  = trie_next[cur][kb ^ 1'b1];
            same = trie_next[cur][kb];
            if (thr_model[b]) begin
                if (opp == 0)
                    walking = 1'b0;
                else
                    cur = opp;
            end else begin
                if (opp != 0 && trie_latest[opp] > best)
                    best = trie_latest[opp];
                if (same == 0)
                    walking = 1'b0;
                else
                    cur = same;
            end
        end
        if (walking && trie_latest[cur] > best)
            best = trie_latest[cur];

        if (best != 0 && best <= seq_pos) begin
            len = seq_pos - best + 1;
            if (seq_shortest == 0 || len < seq_shortest)
                seq_shortest = len;
        end
        res.match_found    = (best != 0);
        res.match_position = OUT_POS_W'(best);
        res.best_length    = OUT_POS_W'(seq_shortest);
        return res;
    endfunction

    // Mix of wide random keys, keys sharing high bits, repeats and near-complements,
    // so that thresholds of every size see both hits and misses.
    function automatic logic [KEY_W-1:0] draw_key();
        int unsigned      pick;
        logic [KEY_W-1:0] k;
        pick = $urandom_range(0, 99);
        if (pick < 35 || recent_keys.size() == 0)
            k = KEY_W'($urandom);
        else if (pick < 65)
            k = {key_base[KEY_W-1:8], 8'($urandom)};
        else if (pick < 82)
            k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        else
            k = ~recent_keys[$urandom_range(0, recent_keys.size() - 1)]
                ^ KEY_W'($urandom_range(0, 3));
        recent_keys.push_back(k);
        if (recent_keys.size() > 16)
            void'(recent_keys.pop_front());
        return k;
    endfunction

    // One input request; the expectation is queued at the accepting edge.
    task automatic send_key(input logic [KEY_W-1:0] key, input bit restart);
        t_in_item    req;
        int unsigned gap;
        req.key            = key;
        req.start_sequence = restart;
        if (pace_random && $urandom_range(0, 31) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= req;
        in_valid <= 1'b1;
        do @(posedge clk); while (!(in_valid && !in_stall));
        window_reports_due.push_back(window_predict(req));
        keys_sent++;
    endtask

    task automatic write_threshold(input logic [KEY_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        thr_model = value;
        settings_used++;
    endtask

    // Every request yields a result, so an empty queue means the block is idle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (window_reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_field(input string field, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $error("tb: %s expected %0d got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Threshold left at its reset value of zero: each key matches itself.
    task automatic test_default_threshold();
        send_key('0, 1'b1);
        send_key('1, 1'b0);
        send_key('0, 1'b0);
        send_key(32'h8000_0000, 1'b0);
        wait_idle();
    endtask

    // Extreme keys against all-ones, top-bit, lowest-bit and all-but-top thresholds.
    task automatic test_edge_keys();
        write_threshold('1);
        send_key('0, 1'b1);
        send_key('1, 1'b0);
        send_key(32'h7FFF_FFFF, 1'b0);
        send_key(32'h8000_0000, 1'b0);
        wait_idle();
        write_threshold(32'h8000_0000);
        send_key(32'h0000_0001, 1'b1);
        send_key(32'h8000_0001, 1'b0);
        send_key(32'h0000_0002, 1'b0);
        send_key(32'h0000_0003, 1'b0);
        wait_idle();
        write_threshold(32'h0000_0001);
        send_key(32'h0000_0005, 1'b1);
        send_key(32'h0000_0005, 1'b0);
        send_key(32'h0000_0004, 1'b0);
        send_key(32'h0000_0005, 1'b1);
        wait_idle();
        write_threshold(32'h7FFF_FFFF);
        send_key('0, 1'b1);
        send_key(32'h7FFF_FFFF, 1'b0);
        send_key('1, 1'b0);
        send_key(32'h0000_0001, 1'b0);
        wait_idle();
    endtask

    // Phases of random keys, each under its own threshold style.
    task automatic test_random_windows();
        int               phase, n;
        logic [KEY_W-1:0] thr;
        bit               restart;
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase % 6)
                0: thr = KEY_W'($urandom);
                1: thr = KEY_W'($urandom_range(0, 255));
                2: thr = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
                3: thr = '1 ^ KEY_W'($urandom_range(0, 7));
                4: thr = '0;
                default: thr = KEY_W'($urandom) >> $urandom_range(0, KEY_W - 1);
            endcase
            write_threshold(thr);
            key_base = KEY_W'($urandom);
            for (n = 0; n < PHASE_KEYS; n++) begin
                restart = (n == 0) ? bit'($urandom_range(0, 1))
                                   : ($urandom_range(0, 49) == 0);
                send_key(draw_key(), restart);
            end
            wait_idle();
        end
    endtask

    // Receiver holds off for a long stretch while keys keep coming, so the
    // result register and the walker back up into the input channel.
    task automatic test_backpressure();
        int n;
        write_threshold(KEY_W'($urandom_range(1, 255)));
        key_base     = KEY_W'($urandom);
        hold_request = HOLD_CYCLES;
        for (n = 0; n < 60; n++)
            send_key(draw_key(), n == 0);
        wait_idle();
    endtask

    // Both sides pinned to no idling, so requests and results follow each
    // other as fast as the block allows.
    task automatic test_steady_stream();
        int n;
        write_threshold(KEY_W'($urandom_range(0, 1023)));
        key_base    = KEY_W'($urandom);
        pace_random = 1'b0;
        tx_steady   = 1'b1;
        rx_steady   = 1'b1;
        for (n = 0; n < STEADY_KEYS; n++)
            send_key(draw_key(), n == 0);
        wait_idle();
        pace_random = 1'b1;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
    endtask

    // Receiver pacing: a random stall before each result, or a requested hold-off.
    initial begin : result_pacing
        int unsigned wait_cycles;
        forever begin
            if (hold_request != 0) begin
                wait_cycles  = hold_request;
                hold_request = 0;
            end else begin
                if (pace_random && $urandom_range(0, 31) == 0)
                    rx_steady = !rx_steady;
                wait_cycles = rx_steady ? 0 : $urandom_range(0, 11);
            end
            if (wait_cycles != 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Compare each accepted result against the oldest expectation.
    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (window_reports_due.size() == 0) begin
                $error("tb: result with no request outstanding");
                mismatches++;
            end else begin
                want = window_reports_due.pop_front();
                report_field("match_found", want.match_found, out_data.match_found);
                report_field("match_position", want.match_position,
                             out_data.match_position);
                report_field("best_length", want.best_length, out_data.best_length);
                report_field("overflow", want.overflow, out_data.overflow);
                reports_checked++;
                if (out_data.match_found)
                    match_reports++;
                if (out_data.overflow)
                    overflow_reports++;
            end
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_threshold();
        test_edge_keys();
        test_random_windows();
        test_backpressure();
        test_steady_stream();
        $display("tb: %0d keys sent, %0d results checked, %0d with a match, %0d dropped",
                 keys_sent, reports_checked, match_reports, overflow_reports);
        $display("tb: %0d threshold settings, one %0d-cycle receiver hold-off",
                 settings_used, HOLD_CYCLES);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule
